@@ src/athkr_pkg.sv @@
// ----------------------------------------------------------------------------
// athkr_pkg
// Shared types, codes and the character classifier for the ascii to hid
// key report block.
// ----------------------------------------------------------------------------
package athkr_pkg;

    localparam int CharWidth  = 8;
    localparam int ModWidth   = 8;
    localparam int UsageWidth = 7;

    // modifier codes
    localparam logic [ModWidth-1:0] MOD_NONE       = 8'h00;
    localparam logic [ModWidth-1:0] MOD_LEFT_SHIFT = 8'h02;

    // usage offsets for the ranges
    localparam logic [CharWidth-1:0] USAGE_LETTER_A = 8'h04;
    localparam logic [CharWidth-1:0] USAGE_DIGIT_1  = 8'h1e;

    // classified character, one queue entry
    typedef struct packed {
        logic                  mapped;
        logic [ModWidth-1:0]   modifier;
        logic [UsageWidth-1:0] usage;
    } key_entry_t;

    // map one ascii byte to its modifier and usage
    function automatic key_entry_t classify_char(input logic [CharWidth-1:0] c);
        key_entry_t          e;
        logic [CharWidth-1:0] off;
        e.mapped   = 1'b1;
        e.modifier = MOD_NONE;
        e.usage    = '0;
        off        = '0;
        if (c inside {[8'h61:8'h7a]}) begin
            // lower-case letters
            off     = c - 8'h61 + USAGE_LETTER_A;
            e.usage = off[UsageWidth-1:0];
        end else if (c inside {[8'h41:8'h5a]}) begin
            // upper-case letters, shifted
            off        = c - 8'h41 + USAGE_LETTER_A;
            e.usage    = off[UsageWidth-1:0];
            e.modifier = MOD_LEFT_SHIFT;
        end else if (c inside {[8'h31:8'h39]}) begin
            // digits one to nine
            off     = c - 8'h31 + USAGE_DIGIT_1;
            e.usage = off[UsageWidth-1:0];
        end else begin
            // punctuation, space, newline and zero
            case (c)
                8'h30: e.usage = 7'h27; // 0
                8'h2d: e.usage = 7'h2d; // -
                8'h3d: e.usage = 7'h2e; // =
                8'h5b: e.usage = 7'h2f; // [
                8'h5d: e.usage = 7'h30; // ]
                8'h5c: e.usage = 7'h31; // backslash
                8'h3b: e.usage = 7'h33; // ;
                8'h27: e.usage = 7'h34; // quote
                8'h60: e.usage = 7'h35; // backtick
                8'h2c: e.usage = 7'h36; // ,
                8'h2e: e.usage = 7'h37; // .
                8'h2f: e.usage = 7'h38; // /
                8'h20: e.usage = 7'h2c; // space
                8'h0a: e.usage = 7'h28; // newline
                8'h7e: begin e.usage = 7'h35; e.modifier = MOD_LEFT_SHIFT; end // ~
                8'h21: begin e.usage = 7'h1e; e.modifier = MOD_LEFT_SHIFT; end // !
                8'h40: begin e.usage = 7'h1f; e.modifier = MOD_LEFT_SHIFT; end // @
                8'h23: begin e.usage = 7'h20; e.modifier = MOD_LEFT_SHIFT; end // #
                8'h24: begin e.usage = 7'h21; e.modifier = MOD_LEFT_SHIFT; end // $
                8'h25: begin e.usage = 7'h22; e.modifier = MOD_LEFT_SHIFT; end // %
                8'h5e: begin e.usage = 7'h23; e.modifier = MOD_LEFT_SHIFT; end // ^
                8'h26: begin e.usage = 7'h24; e.modifier = MOD_LEFT_SHIFT; end // &
                8'h2a: begin e.usage = 7'h25; e.modifier = MOD_LEFT_SHIFT; end // *
                8'h28: begin e.usage = 7'h26; e.modifier = MOD_LEFT_SHIFT; end // (
                8'h29: begin e.usage = 7'h27; e.modifier = MOD_LEFT_SHIFT; end // )
                8'h5f: begin e.usage = 7'h2d; e.modifier = MOD_LEFT_SHIFT; end // _
                8'h2b: begin e.usage = 7'h2e; e.modifier = MOD_LEFT_SHIFT; end // +
                8'h7b: begin e.usage = 7'h2f; e.modifier = MOD_LEFT_SHIFT; end // {
                8'h7d: begin e.usage = 7'h30; e.modifier = MOD_LEFT_SHIFT; end // }
                8'h3a: begin e.usage = 7'h33; e.modifier = MOD_LEFT_SHIFT; end // :
                8'h22: begin e.usage = 7'h34; e.modifier = MOD_LEFT_SHIFT; end // dquote
                8'h7c: begin e.usage = 7'h31; e.modifier = MOD_LEFT_SHIFT; end // |
                8'h3c: begin e.usage = 7'h36; e.modifier = MOD_LEFT_SHIFT; end // <
                8'h3e: begin e.usage = 7'h37; e.modifier = MOD_LEFT_SHIFT; end // >
                8'h3f: begin e.usage = 7'h38; e.modifier = MOD_LEFT_SHIFT; end // ?
                default: e.mapped = 1'b0;
            endcase
        end
        return e;
    endfunction

endpackage

@@ src/athkr_front.sv @@
// ----------------------------------------------------------------------------
// athkr_front
// Accepts ascii bytes and classifies each into a key entry for the queue.
// ----------------------------------------------------------------------------
module athkr_front (
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [athkr_pkg::CharWidth-1:0] s_ascii_char,
    output logic                            push_valid,
    input  logic                            push_ready,
    output athkr_pkg::key_entry_t           push_entry
);
    import athkr_pkg::*;

    // request passes straight to the queue write side
    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    // classify the byte
    assign push_entry = classify_char(s_ascii_char);

endmodule

@@ src/athkr_queue.sv @@
// ----------------------------------------------------------------------------
// athkr_queue
// Two-entry queue of classified key entries between front and back.
// ----------------------------------------------------------------------------
module athkr_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  athkr_pkg::key_entry_t push_entry,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output athkr_pkg::key_entry_t pop_entry
);
    import athkr_pkg::*;

    key_entry_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and count update
    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ src/athkr_back.sv @@
// ----------------------------------------------------------------------------
// athkr_back
// Turns each key entry into a press and a release report, or only the release
// for an unmapped entry, held in an output register.
// ----------------------------------------------------------------------------
module athkr_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             pop_valid,
    output logic                             pop_ready,
    input  athkr_pkg::key_entry_t            pop_entry,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [athkr_pkg::ModWidth-1:0]   m_modifier_bits,
    output logic [athkr_pkg::UsageWidth-1:0] m_key_usage,
    output logic                             m_last_of_char
);
    import athkr_pkg::*;

    logic                  out_valid_reg, out_valid_next;
    logic                  pend_rel_reg, pend_rel_next;
    logic [ModWidth-1:0]   mod_reg, mod_next;
    logic [UsageWidth-1:0] usage_reg, usage_next;
    logic                  last_reg, last_next;
    logic                  load;

    // output register may take a new report
    assign load      = !out_valid_reg || m_ready;
    assign pop_ready = load && !pend_rel_reg;

    // choose the next report
    always_comb begin
        out_valid_next = out_valid_reg;
        pend_rel_next  = pend_rel_reg;
        mod_next       = mod_reg;
        usage_next     = usage_reg;
        last_next      = last_reg;
        if (load) begin
            if (pend_rel_reg) begin
                // release after a press
                out_valid_next = 1'b1;
                pend_rel_next  = 1'b0;
                mod_next       = MOD_NONE;
                usage_next     = '0;
                last_next      = 1'b1;
            end else if (pop_valid) begin
                out_valid_next = 1'b1;
                if (pop_entry.mapped) begin
                    // press report first
                    pend_rel_next = 1'b1;
                    mod_next      = pop_entry.modifier;
                    usage_next    = pop_entry.usage;
                    last_next     = 1'b0;
                end else begin
                    // unmapped byte gives only the release
                    mod_next   = MOD_NONE;
                    usage_next = '0;
                    last_next  = 1'b1;
                end
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            pend_rel_reg  <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            pend_rel_reg  <= pend_rel_next;
        end
    end

    always_ff @(posedge aclk) begin
        mod_reg   <= mod_next;
        usage_reg <= usage_next;
        last_reg  <= last_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_modifier_bits = mod_reg;
    assign m_key_usage     = usage_reg;
    assign m_last_of_char  = last_reg;

endmodule

@@ src/ascii_to_hid_key_reports_core.sv @@
// ----------------------------------------------------------------------------
// ascii_to_hid_key_reports_core
// Converts ascii bytes into hid boot-keyboard press and release reports.
// ----------------------------------------------------------------------------
//  channel  direction  ports                                    per request
//  s_       in         s_ascii_char                             one byte
//  m_       out        m_modifier_bits, m_key_usage,            one report
//                      m_last_of_char
//
//  a mapped byte gives two reports, press then release, an unmapped byte one;
//  the single output register emits one report per cycle while m_ready is
//  high; after a press it emits the release before it pops the next entry.
//  a byte is written to the queue, then its first report to the output reg.
//  a two-entry queue keeps input going while the output stalls.
//  synchronous active-low reset empties the queue and the output register.
module ascii_to_hid_key_reports_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [athkr_pkg::CharWidth-1:0]  s_ascii_char,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [athkr_pkg::ModWidth-1:0]   m_modifier_bits,
    output logic [athkr_pkg::UsageWidth-1:0] m_key_usage,
    output logic                             m_last_of_char
);
    import athkr_pkg::*;

    logic       push_valid, push_ready;
    key_entry_t push_entry;
    logic       pop_valid, pop_ready;
    key_entry_t pop_entry;

    // accept and classify
    athkr_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_ascii_char (s_ascii_char),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_entry   (push_entry)
    );

    // decoupling queue
    athkr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // report generation
    athkr_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_entry       (pop_entry),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_modifier_bits (m_modifier_bits),
        .m_key_usage     (m_key_usage),
        .m_last_of_char  (m_last_of_char)
    );

endmodule

@@ tb/sv/tb_ascii_to_hid_key_reports_core.sv @@
// ----------------------------------------------------------------------------
// tb_ascii_to_hid_key_reports_core
// Self-checking bench for the ascii to hid key report core: drives ascii
// bytes in bursts, predicts press and release reports per byte from a
// keyboard-layout view of the characters, and checks every report in order
// while the output side stalls on its own pattern.
// ----------------------------------------------------------------------------

// one expected key report
typedef struct {
    logic [athkr_pkg::ModWidth-1:0]   modifier;
    logic [athkr_pkg::UsageWidth-1:0] usage;
    logic                             ends_char;
} hid_report_t;

class key_report_scoreboard;

    hid_report_t  expected_reports[$];
    int unsigned  chars_seen;
    int unsigned  chars_mapped;
    int unsigned  chars_shifted;
    int unsigned  reports_checked;
    int unsigned  mismatches;

    function new();
        chars_seen      = 0;
        chars_mapped    = 0;
        chars_shifted   = 0;
        reports_checked = 0;
        mismatches      = 0;
    endfunction

    // shifted symbols share the key of their unshifted twin
    function bit shifted_twin(input logic [7:0] c, output logic [7:0] twin);
        shifted_twin = 1'b1;
        case (c)
            8'h21:   twin = 8'h31; // ! on 1
            8'h40:   twin = 8'h32; // @ on 2
            8'h23:   twin = 8'h33; // # on 3
            8'h24:   twin = 8'h34; // $ on 4
            8'h25:   twin = 8'h35; // % on 5
            8'h5e:   twin = 8'h36; // ^ on 6
            8'h26:   twin = 8'h37; // & on 7
            8'h2a:   twin = 8'h38; // * on 8
            8'h28:   twin = 8'h39; // ( on 9
            8'h29:   twin = 8'h30; // ) on 0
            8'h5f:   twin = 8'h2d; // _ on -
            8'h2b:   twin = 8'h3d; // + on =
            8'h7b:   twin = 8'h5b; // { on [
            8'h7d:   twin = 8'h5d; // } on ]
            8'h3a:   twin = 8'h3b; // colon on semicolon
            8'h22:   twin = 8'h27; // double quote on quote
            8'h7c:   twin = 8'h5c; // pipe on backslash
            8'h3c:   twin = 8'h2c; // < on comma
            8'h3e:   twin = 8'h2e; // > on period
            8'h3f:   twin = 8'h2f; // ? on slash
            8'h7e:   twin = 8'h60; // tilde on backtick
            default: begin
                twin         = c;
                shifted_twin = 1'b0;
            end
        endcase
    endfunction

    // key of an unshifted character, 0 when no key produces it
    function logic [6:0] plain_key(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7a) begin
            return 7'(c - 8'h61) + 7'd4;
        end
        if (c >= 8'h31 && c <= 8'h39) begin
            return 7'(c - 8'h31) + 7'h1e;
        end
        case (c)
            8'h30:   return 7'h27; // 0
            8'h0a:   return 7'h28; // newline
            8'h20:   return 7'h2c; // space
            8'h2d:   return 7'h2d; // -
            8'h3d:   return 7'h2e; // =
            8'h5b:   return 7'h2f; // [
            8'h5d:   return 7'h30; // ]
            8'h5c:   return 7'h31; // backslash
            8'h3b:   return 7'h33; // semicolon
            8'h27:   return 7'h34; // quote
            8'h60:   return 7'h35; // backtick
            8'h2c:   return 7'h36; // comma
            8'h2e:   return 7'h37; // period
            8'h2f:   return 7'h38; // slash
            default: return 7'h00;
        endcase
    endfunction

    function int unsigned pending();
        return expected_reports.size();
    endfunction

    task report_mismatch(input string what, input int unsigned got, input int unsigned want);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // predict the reports of one accepted byte
    function void note_char(input logic [7:0] c);
        hid_report_t rep;
        logic [7:0]  base;
        logic [6:0]  key;
        bit          shifted;
        chars_seen++;
        shifted = 1'b0;
        if (c >= 8'h41 && c <= 8'h5a) begin
            base    = c + 8'h20;
            shifted = 1'b1;
        end else begin
            shifted = shifted_twin(c, base);
        end
        key = plain_key(base);
        // press report only when some key gives the character
        if (key != 7'h00) begin
            rep.modifier  = shifted ? athkr_pkg::MOD_LEFT_SHIFT : athkr_pkg::MOD_NONE;
            rep.usage     = key;
            rep.ends_char = 1'b0;
            expected_reports.push_back(rep);
            chars_mapped++;
            if (shifted) chars_shifted++;
        end
        // release report always closes the character
        rep.modifier  = athkr_pkg::MOD_NONE;
        rep.usage     = '0;
        rep.ends_char = 1'b1;
        expected_reports.push_back(rep);
    endfunction

    // compare one accepted report with the oldest prediction
    task check_report(input logic [7:0] modv, input logic [6:0] usage, input logic ends);
        hid_report_t want;
        reports_checked++;
        if (expected_reports.size() == 0) begin
            report_mismatch("report with nothing pending, usage", usage, 0);
        end else begin
            want = expected_reports.pop_front();
            if (modv !== want.modifier)
                report_mismatch("modifier_bits", modv, want.modifier);
            if (usage !== want.usage)
                report_mismatch("key_usage", usage, want.usage);
            if (ends !== want.ends_char)
                report_mismatch("last_of_char", ends, want.ends_char);
        end
    endtask

endclass

module tb_ascii_to_hid_key_reports_core;
    timeunit 1ns;
    timeprecision 1ps;

    import athkr_pkg::*;

    localparam int          HALF_PERIOD  = 10;
    localparam int          RESET_CYCLES = 7;
    localparam int          RANDOM_CHARS = 1425;
    localparam int          HOLD_AT      = 450;
    localparam int          PAUSE_AT     = 950;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_LIMIT  = 20000;
    localparam int          TAIL_CYCLES  = 8;
    localparam longint      TIMEOUT_NS   = 5_000_000;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [CharWidth-1:0]  s_ascii_char = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [ModWidth-1:0]   m_modifier_bits;
    logic [UsageWidth-1:0] m_key_usage;
    logic                  m_last_of_char;

    key_report_scoreboard  sb;

    // output hold-off requests, counted by the receiver
    int unsigned hold_req  = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned rx_cycle  = 0;

    // extremes, every key class and the unmapped cases
    logic [7:0] directed_chars [24] = '{
        8'h00, 8'hff, 8'h7f, 8'h80, 8'h61, 8'h7a, 8'h41, 8'h5a,
        8'h31, 8'h39, 8'h30, 8'h0a, 8'h20, 8'h7e, 8'h3f, 8'h60,
        8'h09, 8'h0d, 8'h21, 8'h29, 8'h7b, 8'h7c, 8'h5c, 8'h01
    };

    ascii_to_hid_key_reports_core u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_ascii_char    (s_ascii_char),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_modifier_bits (m_modifier_bits),
        .m_key_usage     (m_key_usage),
        .m_last_of_char  (m_last_of_char)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // receiver: check reports, stall on a rotating pattern
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_report(m_modifier_bits, m_key_usage, m_last_of_char);
        end
        rx_cycle++;
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case ((rx_cycle / 256) % 4)
                0:       m_ready <= 1'b1;
                1:       m_ready <= ($urandom_range(0, 1) == 0);
                2:       m_ready <= (rx_cycle % 4 == 0);
                default: m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // offer one byte and hold it until taken
    task automatic send_char(input logic [7:0] c);
        s_valid      <= 1'b1;
        s_ascii_char <= c;
        do @(posedge aclk); while (!s_ready);
        sb.note_char(c);
    endtask

    task automatic idle_sender(input int unsigned cycles);
        if (cycles != 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // wait until every predicted report has come back or the guard limit runs out
    task automatic drain_reports();
        int unsigned guard;
        guard = 0;
        s_valid <= 1'b0;
        while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
    endtask

    // mostly text, some controls and high bytes
    function automatic logic [7:0] pick_char();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 8'($urandom_range(8'h20, 8'h7e));
        if (r < 56) return 8'($urandom_range(8'h61, 8'h7a));
        if (r < 62) return 8'($urandom_range(8'h41, 8'h5a));
        if (r < 68) return 8'h0a;
        if (r < 78) return ($urandom_range(0, 4) == 0) ? 8'h7f : 8'($urandom_range(0, 8'h1f));
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        int unsigned sent;
        int unsigned burst;
        bit          hold_done;
        bit          pause_done;

        sb         = new();
        sent       = 0;
        hold_done  = 1'b0;
        pause_done = 1'b0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed bytes back to back
        foreach (directed_chars[i]) send_char(directed_chars[i]);
        idle_sender($urandom_range(1, 5));

        // random bursts with random gaps
        while (sent < RANDOM_CHARS) begin
            if (!hold_done && sent >= HOLD_AT) begin
                // long output hold-off while input keeps coming
                hold_done = 1'b1;
                hold_req <= hold_req + 1;
                repeat (40) send_char(pick_char());
                sent += 40;
            end else if (!pause_done && sent >= PAUSE_AT) begin
                pause_done = 1'b1;
                drain_reports();
            end
            burst = $urandom_range(1, 40);
            repeat (burst) send_char(pick_char());
            sent += burst;
            if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 12));
        end

        drain_reports();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.pending() != 0) sb.report_mismatch("reports never produced", 0, sb.pending());

        $display("summary: %0d bytes sent, %0d with a key (%0d shifted), %0d without",
                 sb.chars_seen, sb.chars_mapped, sb.chars_shifted,
                 sb.chars_seen - sb.chars_mapped);
        $display("summary: %0d reports checked across stall patterns, a long hold-off and a drain",
                 sb.reports_checked);
        if (sb.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule
